>>> sv/stable_priority_queue_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stable priority queue
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define SPQ_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define SPQ_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes of the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Default number of queue slots
   localparam int CAPACITY_DEF = 64;

   // Field widths
   localparam int ID_W     = 16;
   localparam int KIND_W   = 8;
   localparam int PRIO_W   = 32;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 7;

   // Commands
   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
   localparam logic [STATUS_W-1:0] ST_NULL  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUP   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_FULL  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

   // One stored queue entry
   typedef struct packed {
      logic [ID_W-1:0]          handle;
      logic [KIND_W-1:0]        kind;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   // Outcome of comparing one stored entry against the pending insert
   typedef struct packed {
      logic hit;    // same handle
      logic after;  // stored entry leaves after the new one
   } cmp_res_type;

endpackage

>>> sv/spq_channels.sv
// ----------------------------------------------------------------------------
// spq channels
// Valid/ready channel interfaces for request and response items.
// ----------------------------------------------------------------------------
interface spq_req_if;
   import spq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [ID_W-1:0]          item_id;
   logic [KIND_W-1:0]        kind;
   logic signed [PRIO_W-1:0] priority_req;

   modport source (output valid, command, item_id, kind, priority_req, input ready);
   modport sink   (input valid, command, item_id, kind, priority_req, output ready);
endinterface

interface spq_rsp_if;
   import spq_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [ID_W-1:0]          out_item_id;
   logic [KIND_W-1:0]        out_kind;
   logic signed [PRIO_W-1:0] out_priority;
   logic [COUNT_W-1:0]       entry_count;

   modport source (output valid, status, out_item_id, out_kind, out_priority,
                   entry_count, input ready);
   modport sink   (input valid, status, out_item_id, out_kind, out_priority,
                   entry_count, output ready);
endinterface

>>> sv/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_store #(
   parameter int DEPTH = spq_pkg::CAPACITY_DEF,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  spq_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output spq_pkg::entry_type  rd_data
);
   import spq_pkg::*;

   entry_type mem_ff [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/spq_cmp.sv
// ----------------------------------------------------------------------------
// spq_cmp
// Shared compare unit: handle match and signed priority order of one entry.
// ----------------------------------------------------------------------------
module spq_cmp (
   input  spq_pkg::entry_type    stored,
   input  spq_pkg::entry_type    key,
   output spq_pkg::cmp_res_type  res
);
   import spq_pkg::*;

   // stored entry leaves after the new one only on strictly greater priority,
   // so equal priorities keep arrival order
   always_comb begin
      res.hit   = (stored.handle == key.handle);
      res.after = (stored.prio > key.prio);
   end

endmodule

>>> sv/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// Bounded min-priority queue of event entries with arrival order on ties.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one command per item: insert (handle, kind, priority) or
//   remove the lowest-priority entry. rsp_bus returns exactly one item per
//   request with status, the removed entry (zero otherwise) and the count.
//   Entries sit in a circular memory, sorted from the head slot onward.
//   A sequencer walks the memory through one compare unit, one slot a cycle.
// Steps (from request accept to response valid):
//   remove: POP reads the head entry, then FIN; remove from empty or insert of
//   a null handle: straight to FIN. insert: SCAN over the queued entries,
//   SHIFT per entry behind the new one, INSERT, FIN; rejected insert: SCAN, FIN.
//   The block takes no new request until the current one has finished.
// Reset: synchronous, empties the queue; memory contents are not cleared.
// Stall: a finished response waits in the output register; the request side
//   is ready again once the response is loaded, and the next one waits in
//   its final state until the output register is free.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_assert.svh"

module stable_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   spq_req_if.sink     req_bus,
   spq_rsp_if.source   rsp_bus
);
   import spq_pkg::*;

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SCAN   = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_INSERT = 3'd3;
   localparam logic [2:0] S_POP    = 3'd4;
   localparam logic [2:0] S_FIN    = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       head_ff, head_in;
   entry_type           req_ent_ff, req_ent_in;
   logic [CW-1:0]       scan_ff, scan_in;
   logic                dup_ff, dup_in;
   logic                found_ff, found_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic [CW-1:0]       shift_ff, shift_in;
   logic [STATUS_W-1:0] stat_ff, stat_in;
   entry_type           res_ent_ff, res_ent_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   entry_type           rsp_ent_ff, rsp_ent_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                mem_wr_en, mem_rd_en;
   logic [CW-1:0]       wr_log, rd_log;
   logic [AW-1:0]       wr_addr, rd_addr;
   entry_type           wr_data, rd_data;
   cmp_res_type         cmp_res;

   logic                accept;
   logic                dup_now, found_now, last_scan;
   logic [CW-1:0]       pos_now, pos_final;
   logic [CW+COUNT_W-1:0] count_ext;

   // logical slot to memory address, wrapping around the head
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                          input logic [CW-1:0] idx);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + (CW+1)'(idx);
      if (sum >= (CW+1)'(CAPACITY)) begin
         sum = sum - (CW+1)'(CAPACITY);
      end
      return sum[AW-1:0];
   endfunction

   spq_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   spq_cmp u_cmp (
      .stored (rd_data),
      .key    (req_ent_ff),
      .res    (cmp_res)
   );

   assign accept  = req_bus.valid && req_bus.ready;
   assign wr_addr = phys(head_ff, wr_log);
   assign rd_addr = phys(head_ff, rd_log);

   // scan bookkeeping for the entry on the read port
   assign dup_now   = dup_ff || cmp_res.hit;
   assign found_now = found_ff || cmp_res.after;
   assign pos_now   = (!found_ff && cmp_res.after) ? scan_ff : pos_ff;
   assign pos_final = found_now ? pos_now : count_ff;
   assign last_scan = (scan_ff == CW'(count_ff - 1'b1));
   assign count_ext = (CW+COUNT_W)'(count_ff);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      req_ent_in    = req_ent_ff;
      scan_in       = scan_ff;
      dup_in        = dup_ff;
      found_in      = found_ff;
      pos_in        = pos_ff;
      shift_in      = shift_ff;
      stat_in       = stat_ff;
      res_ent_in    = res_ent_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_status_in = rsp_status_ff;
      rsp_ent_in    = rsp_ent_ff;
      rsp_count_in  = rsp_count_ff;
      mem_wr_en     = 1'b0;
      mem_rd_en     = 1'b0;
      wr_log        = '0;
      rd_log        = '0;
      wr_data       = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_ent_in.handle = req_bus.item_id;
               req_ent_in.kind   = req_bus.kind;
               req_ent_in.prio   = req_bus.priority_req;
               res_ent_in        = '0;
               if (req_bus.command == CMD_REMOVE) begin
                  if (count_ff == '0) begin
                     stat_in  = ST_EMPTY;
                     state_in = S_FIN;
                  end else begin
                     mem_rd_en = 1'b1;
                     state_in  = S_POP;
                  end
               end else if (req_bus.item_id == '0) begin
                  stat_in  = ST_NULL;
                  state_in = S_FIN;
               end else if (count_ff == '0) begin
                  pos_in   = '0;
                  state_in = S_INSERT;
               end else begin
                  mem_rd_en = 1'b1;
                  scan_in   = '0;
                  dup_in    = 1'b0;
                  found_in  = 1'b0;
                  pos_in    = '0;
                  state_in  = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            dup_in   = dup_now;
            found_in = found_now;
            pos_in   = pos_now;
            if (!last_scan) begin
               mem_rd_en = 1'b1;
               rd_log    = CW'(scan_ff + 1'b1);
               scan_in   = CW'(scan_ff + 1'b1);
            end else if (dup_now) begin
               stat_in  = ST_DUP;
               state_in = S_FIN;
            end else if (count_ff == CW'(CAPACITY)) begin
               stat_in  = ST_FULL;
               state_in = S_FIN;
            end else begin
               pos_in = pos_final;
               if (pos_final == count_ff) begin
                  state_in = S_INSERT;
               end else begin
                  // fetch the last entry; it moves up first
                  mem_rd_en = 1'b1;
                  rd_log    = CW'(count_ff - 1'b1);
                  shift_in  = count_ff;
                  state_in  = S_SHIFT;
               end
            end
         end
         S_SHIFT: begin
            // slot shift_ff takes the entry below it, next one is fetched
            mem_wr_en = 1'b1;
            wr_log    = shift_ff;
            wr_data   = rd_data;
            if (CW'(shift_ff - 1'b1) == pos_ff) begin
               state_in = S_INSERT;
            end else begin
               mem_rd_en = 1'b1;
               rd_log    = CW'(shift_ff - 2'd2);
               shift_in  = CW'(shift_ff - 1'b1);
            end
         end
         S_INSERT: begin
            mem_wr_en = 1'b1;
            wr_log    = pos_ff;
            wr_data   = req_ent_ff;
            count_in  = CW'(count_ff + 1'b1);
            stat_in   = ST_OK;
            state_in  = S_FIN;
         end
         S_POP: begin
            res_ent_in = rd_data;
            stat_in    = ST_OK;
            count_in   = CW'(count_ff - 1'b1);
            head_in    = (head_ff == AW'(CAPACITY - 1)) ? '0 : AW'(head_ff + 1'b1);
            state_in   = S_FIN;
         end
         S_FIN: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = stat_ff;
               rsp_ent_in    = res_ent_ff;
               rsp_count_in  = count_ext[COUNT_W-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         head_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         head_ff      <= head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working and result registers
   always_ff @(posedge clock) begin
      req_ent_ff    <= req_ent_in;
      scan_ff       <= scan_in;
      dup_ff        <= dup_in;
      found_ff      <= found_in;
      pos_ff        <= pos_in;
      shift_ff      <= shift_in;
      stat_ff       <= stat_in;
      res_ent_ff    <= res_ent_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ent_ff    <= rsp_ent_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // ports
   assign req_bus.ready        = (state_ff == S_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.out_item_id  = rsp_ent_ff.handle;
   assign rsp_bus.out_kind     = rsp_ent_ff.kind;
   assign rsp_bus.out_priority = rsp_ent_ff.prio;
   assign rsp_bus.entry_count  = rsp_count_ff;

   // checks
   `SPQ_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(CAPACITY), "count above capacity")
   `SPQ_ASSERT_ALWAYS(a_head_bound, clock, reset, head_ff <= AW'(CAPACITY - 1), "head out of range")
   `SPQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_bus.ready, "ready right after accept")
   `SPQ_ASSERT_SAME(a_empty_count, clock, reset, rsp_valid_ff && rsp_status_ff == ST_EMPTY, rsp_count_ff == '0, "empty status with nonzero count")

endmodule

>>> sim/tb_stable_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Self-checking testbench for the stable priority queue. A shadow queue,
// kept sorted with ties in arrival order, predicts the response of every
// accepted request. A checker compares each accepted response with the
// oldest prediction. Directed tests cover the empty, null, duplicate, full
// and tie cases. Random traffic with idling on both sides follows, plus
// output backpressure that fills the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stable_priority_queue;
   import spq_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 2 * CAPACITY_DEF + 8;
   localparam logic signed [PRIO_W-1:0] PRIO_MIN = 32'sh8000_0000;
   localparam logic signed [PRIO_W-1:0] PRIO_MAX = 32'sh7FFF_FFFF;

   // One response item as the block should return it
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [ID_W-1:0]          item_id;
      logic [KIND_W-1:0]        kind;
      logic signed [PRIO_W-1:0] prio;
      logic [COUNT_W-1:0]       n_entries;
   } result_type;

   logic clock;
   logic reset;

   spq_req_if req_bus ();
   spq_rsp_if rsp_bus ();

   stable_priority_queue dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Shadow of the queue contents, head first
   entry_type  sorted_entries[$];
   // Responses owed by the block, oldest first
   result_type due_responses[$];

   bit          sender_idles   = 1'b1;
   bit          receiver_idles = 1'b1;
   int unsigned hold_cycles    = 0;
   int          err_count      = 0;
   int          quiet_cycles   = 0;

   initial clock = 1'b0;
   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------
   function automatic bit handle_held(logic [ID_W-1:0] id);
      foreach (sorted_entries[i])
         if (sorted_entries[i].handle == id) return 1'b1;
      return 1'b0;
   endfunction

   // Apply one command to the shadow queue, return the response it owes
   function automatic result_type apply_command(logic cmd, logic [ID_W-1:0] id,
                                                logic [KIND_W-1:0] kd,
                                                logic signed [PRIO_W-1:0] pr);
      result_type r;
      entry_type  e;
      int         pos;
      r = '0;
      if (cmd == CMD_INSERT) begin
         if (id == '0) begin
            r.status = ST_NULL;
         end else if (handle_held(id)) begin
            r.status = ST_DUP;
         end else if (sorted_entries.size() >= CAPACITY_DEF) begin
            r.status = ST_FULL;
         end else begin
            // new entry goes behind every entry of lower or equal priority
            pos = 0;
            while (pos < sorted_entries.size() &&
                   $signed(sorted_entries[pos].prio) <= $signed(pr))
               pos++;
            e.handle = id;
            e.kind   = kd;
            e.prio   = pr;
            sorted_entries.insert(pos, e);
            r.status = ST_OK;
         end
      end else if (sorted_entries.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         e         = sorted_entries.pop_front();
         r.status  = ST_OK;
         r.item_id = e.handle;
         r.kind    = e.kind;
         r.prio    = e.prio;
      end
      r.n_entries = COUNT_W'(sorted_entries.size());
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic logic [ID_W-1:0] draw_free_handle();
      logic [ID_W-1:0] id;
      do id = ID_W'($urandom_range(1, 65535)); while (handle_held(id));
      return id;
   endfunction

   function automatic logic [ID_W-1:0] pick_queued_handle();
      return sorted_entries[$urandom_range(0, sorted_entries.size() - 1)].handle;
   endfunction

   // Mostly a narrow band so ties are common, some full range and extremes
   function automatic logic signed [PRIO_W-1:0] draw_priority();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return ($urandom_range(0, 1) != 0) ? PRIO_MAX : PRIO_MIN;
      if (sel <= 5) return $signed($urandom_range(0, 8)) - 4;
      return $signed($urandom);
   endfunction

   // Offer one request item, predict its response once accepted
   task automatic send_item(logic cmd, logic [ID_W-1:0] id, logic [KIND_W-1:0] kd,
                            logic signed [PRIO_W-1:0] pr);
      int gap;
      gap = sender_idles ? $urandom_range(0, 19) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.command      <= cmd;
      req_bus.item_id      <= id;
      req_bus.kind         <= kd;
      req_bus.priority_req <= pr;
      do @(posedge clock); while (!req_bus.ready);
      due_responses.push_back(apply_command(cmd, id, kd, pr));
   endtask

   task automatic insert_entry(logic [ID_W-1:0] id, logic [KIND_W-1:0] kd,
                               logic signed [PRIO_W-1:0] pr);
      send_item(CMD_INSERT, id, kd, pr);
   endtask

   // Payload of a remove is don't-care, so it carries noise
   task automatic remove_entry();
      send_item(CMD_REMOVE, ID_W'($urandom), KIND_W'($urandom), $signed($urandom));
   endtask

   // One random item: insert with given percentage, else remove
   task automatic random_item(int insert_pct);
      int sel;
      if ($urandom_range(0, 99) < insert_pct) begin
         sel = $urandom_range(0, 99);
         if (sel < 4)
            insert_entry('0, KIND_W'($urandom), draw_priority());
         else if (sel < 10 && sorted_entries.size() > 0)
            insert_entry(pick_queued_handle(), KIND_W'($urandom), draw_priority());
         else
            insert_entry(draw_free_handle(), KIND_W'($urandom), draw_priority());
      end else begin
         remove_entry();
      end
   endtask

   // Stop offering and wait until every owed response has come back
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (due_responses.size() > 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_empty_and_null();
      remove_entry();
      insert_entry('0, 8'hFF, PRIO_MAX);
      insert_entry('0, 8'h00, PRIO_MIN);
      remove_entry();
   endtask

   // Field extremes, ties at zero and at both ends, rejects on a busy queue
   task automatic test_order_and_ties();
      insert_entry(16'hFFFF, 8'hFF, PRIO_MIN);
      insert_entry(16'h0001, 8'h00, PRIO_MAX);
      insert_entry(16'h8000, 8'hA5, 0);
      insert_entry(16'h0002, 8'h5A, 0);
      insert_entry(16'h0003, 8'h01, 0);
      insert_entry(16'h7FFF, 8'h80, -1);
      insert_entry(16'h0004, 8'h7F, 1);
      insert_entry(16'h0005, 8'h10, PRIO_MAX);
      insert_entry(16'h0006, 8'h20, PRIO_MIN);
      insert_entry(16'hFFFF, 8'h00, 5);
      insert_entry(16'h0003, 8'h00, 0);
      insert_entry('0, 8'h33, 7);
      repeat (10) remove_entry();
   endtask

   // Fill to capacity, check reject precedence, then drain past empty
   task automatic test_full_queue();
      while (sorted_entries.size() < CAPACITY_DEF)
         insert_entry(draw_free_handle(), KIND_W'($urandom), draw_priority());
      insert_entry(draw_free_handle(), KIND_W'($urandom), draw_priority());
      insert_entry(pick_queued_handle(), KIND_W'($urandom), draw_priority());
      insert_entry('0, KIND_W'($urandom), draw_priority());
      insert_entry(draw_free_handle(), KIND_W'($urandom), PRIO_MIN);
      while (sorted_entries.size() > 0) remove_entry();
      remove_entry();
   endtask

   // Receiver holds off while the sender keeps offering, then sender pauses
   task automatic test_backpressure();
      wait_drained();
      sender_idles = 1'b0;
      hold_cycles  = 200;
      repeat (24) random_item(70);
      wait_drained();
      sender_idles = 1'b1;
      hold_cycles  = 150;
      repeat (16) random_item(60);
      wait_drained();
   endtask

   // Chunks with different insert mix so the fill level wanders end to end
   task automatic test_random_traffic();
      int mix[8] = '{60, 90, 30, 50, 85, 20, 70, 50};
      for (int chunk = 0; chunk < 8; chunk++) begin
         sender_idles   = (chunk != 3);
         receiver_idles = (chunk != 3) && (chunk != 6);
         repeat (75) random_item(mix[chunk]);
         if (chunk == 4) wait_drained();
      end
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
   endtask

   // ------------------------------------------------------------------
   // Response side: random stalls, long hold on request, check each item
   // ------------------------------------------------------------------
   initial begin
      int         stall;
      result_type want;
      result_type got;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = (receiver_idles ? $urandom_range(0, 19) : 0) + hold_cycles;
         hold_cycles = 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         got.status    = rsp_bus.status;
         got.item_id   = rsp_bus.out_item_id;
         got.kind      = rsp_bus.out_kind;
         got.prio      = rsp_bus.out_priority;
         got.n_entries = rsp_bus.entry_count;
         if (due_responses.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("%0t: response item with nothing outstanding: status %0d",
                        $realtime, got.status);
         end else begin
            want = due_responses.pop_front();
            if (got.status !== want.status || got.item_id !== want.item_id ||
                got.kind !== want.kind || got.prio !== want.prio ||
                got.n_entries !== want.n_entries) begin
               err_count++;
               if (err_count <= 10) begin
                  $write("%0t: mismatch: expected st %0d id %h kind %h prio %0d cnt %0d,",
                         $realtime, want.status, want.item_id, want.kind, want.prio,
                         want.n_entries);
                  $display(" got st %0d id %h kind %h prio %0d cnt %0d", got.status,
                           got.item_id, got.kind, got.prio, got.n_entries);
               end
            end
         end
      end
   end

   // Watchdog: too long without any item moving on either side
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Sequence of tests
   // ------------------------------------------------------------------
   initial begin
      req_bus.valid        <= 1'b0;
      req_bus.command      <= CMD_INSERT;
      req_bus.item_id      <= '0;
      req_bus.kind         <= '0;
      req_bus.priority_req <= '0;
      reset                <= 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_empty_and_null();
      test_order_and_ties();
      test_full_queue();
      test_backpressure();
      test_random_traffic();

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
